[rtl/cilc_pkg.sv]
// Shared types, codes and character-class helpers for the integer literal classifier.
// No dependencies; every other file but cilc_if refers to it by scoped names.
package cilc_pkg;

	// token phase codes
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEX    = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_SUFFIX = 3'd5;
	localparam logic [2:0] PH_FAIL   = 3'd6;

	// radix codes
	localparam logic [1:0] RC_NONE = 2'd0;
	localparam logic [1:0] RC_OCT  = 2'd1;
	localparam logic [1:0] RC_DEC  = 2'd2;
	localparam logic [1:0] RC_HEX  = 2'd3;

	localparam logic [4:0] RADIX_OCT = 5'd8;
	localparam logic [4:0] RADIX_DEC = 5'd10;
	localparam logic [4:0] RADIX_HEX = 5'd16;
	localparam logic [4:0] RADIX_NONE = 5'd0;

	// suffix kinds; SFX_BAD marks a rejected suffix
	localparam logic [2:0] SFX_NONE = 3'd0;
	localparam logic [2:0] SFX_L    = 3'd1;
	localparam logic [2:0] SFX_U    = 3'd2;
	localparam logic [2:0] SFX_UL   = 3'd3;
	localparam logic [2:0] SFX_LL   = 3'd4;
	localparam logic [2:0] SFX_ULL  = 3'd5;
	localparam logic [2:0] SFX_BAD  = 3'd6;

	// suffix store depth and count limits
	localparam int unsigned SUF_DEPTH = 3;
	localparam logic [2:0] SUF_FULL = 3'd3;
	localparam logic [2:0] SUF_OVER = 3'd4;
	localparam logic [2:0] SUF_ONE  = 3'd1;
	localparam logic [2:0] SUF_TWO  = 3'd2;

	// width of the reported digit span
	localparam int unsigned OUT_SPAN_BITS = 16;

	// depth of the queue between front and back
	localparam int unsigned Q_DEPTH = 2;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	// summary of one finished token, less its digit span
	typedef struct packed {
		logic [2:0]       phase;
		logic             failed;
		logic [1:0]       radix_code;
		logic             minus;
		logic [2:0]       suf_count;
		logic [2:0][7:0]  suf_chars;
	} cilc_tok_t;

	function automatic logic is_dec(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h37;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic is_l(input logic [7:0] c);
		return c == 8'h4C || c == 8'h6C;
	endfunction

	function automatic logic is_u(input logic [7:0] c);
		return c == 8'h55 || c == 8'h75;
	endfunction

endpackage

[rtl/cilc_if.sv]
// Valid/ready channel interfaces for character items and result items.
// Depends on nothing; used by the classifier top level.
interface cilc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, ch, last, input ready);
	modport sink   (input valid, ch, last, output ready);
endinterface

interface cilc_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [4:0]  radix;
	logic        negative;
	logic [15:0] span_len;
	logic [2:0]  suffix_kind;

	modport source (output valid, valid_res, radix, negative, span_len, suffix_kind,
		input ready);
	modport sink   (input valid, valid_res, radix, negative, span_len, suffix_kind,
		output ready);
endinterface

[rtl/cilc_front.sv]
// Front end: takes one character per item and tracks the token phase.
// Depends on cilc_pkg; pushes a token summary on the token's last character.
module cilc_front #(
	parameter int unsigned SPAN_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              ch,
	input  logic                    last,
	output logic                    push,
	input  logic                    q_ready,
	output cilc_pkg::cilc_tok_t     tok,
	output logic [SPAN_BITS-1:0]    tok_span
);

	logic [2:0]           phase_q, phase_n;
	logic                 minus_q, minus_n;
	logic [1:0]           radix_q, radix_n;
	logic                 failed_q, failed_n;
	logic [SPAN_BITS-1:0] span_q, span_n;
	logic [2:0]           cnt_q, cnt_n;
	logic [2:0][7:0]      suf_q, suf_n;
	logic                 do_inc, do_push, digit_ok, accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last;

	// check a character against the digits of the current radix
	always_comb begin
		case (radix_q)
			cilc_pkg::RC_OCT: digit_ok = cilc_pkg::is_oct(ch);
			cilc_pkg::RC_DEC: digit_ok = cilc_pkg::is_dec(ch);
			default:          digit_ok = cilc_pkg::is_hex(ch);
		endcase
	end

	// advance the token phase by one character
	always_comb begin
		phase_n  = phase_q;
		minus_n  = minus_q;
		radix_n  = radix_q;
		failed_n = failed_q;
		do_inc   = 1'b0;
		do_push  = 1'b0;
		unique case (phase_q) inside
			cilc_pkg::PH_START, cilc_pkg::PH_FIRST: begin
				if (phase_q == cilc_pkg::PH_START && ch == cilc_pkg::CH_MINUS) begin
					minus_n = 1'b1;
					phase_n = cilc_pkg::PH_FIRST;
				end else if (!cilc_pkg::is_dec(ch)) begin
					failed_n = 1'b1;
					phase_n  = cilc_pkg::PH_FAIL;
				end else begin
					do_inc = 1'b1;
					if (ch == cilc_pkg::CH_ZERO) begin
						phase_n = cilc_pkg::PH_ZERO;
					end else begin
						radix_n = cilc_pkg::RC_DEC;
						phase_n = cilc_pkg::PH_DIGITS;
					end
				end
			end
			cilc_pkg::PH_ZERO: begin
				if (ch == cilc_pkg::CH_X_UP || ch == cilc_pkg::CH_X_LO) begin
					do_inc  = 1'b1;
					phase_n = cilc_pkg::PH_HEX;
				end else begin
					radix_n = cilc_pkg::RC_OCT;
					if (cilc_pkg::is_oct(ch)) begin
						do_inc  = 1'b1;
						phase_n = cilc_pkg::PH_DIGITS;
					end else begin
						do_push = 1'b1;
						phase_n = cilc_pkg::PH_SUFFIX;
					end
				end
			end
			cilc_pkg::PH_DIGITS: begin
				if (digit_ok) begin
					do_inc = 1'b1;
				end else begin
					do_push = 1'b1;
					phase_n = cilc_pkg::PH_SUFFIX;
				end
			end
			cilc_pkg::PH_SUFFIX: begin
				do_push = 1'b1;
			end
			cilc_pkg::PH_HEX: begin
				if (!cilc_pkg::is_hex(ch)) begin
					failed_n = 1'b1;
					phase_n  = cilc_pkg::PH_FAIL;
				end else begin
					do_inc  = 1'b1;
					radix_n = cilc_pkg::RC_HEX;
					phase_n = cilc_pkg::PH_DIGITS;
				end
			end
			default: begin
			end
		endcase
	end

	// saturating span count and suffix store update
	always_comb begin
		span_n = span_q;
		if (do_inc && span_q != '1) begin
			span_n = span_q + 1'b1;
		end
		cnt_n = cnt_q;
		suf_n = suf_q;
		if (do_push) begin
			if (cnt_q < cilc_pkg::SUF_FULL) begin
				suf_n[cnt_q[1:0]] = ch;
			end
			if (cnt_q < cilc_pkg::SUF_OVER) begin
				cnt_n = cnt_q + 3'd1;
			end
		end
	end

	// token summary as seen after the last character
	always_comb begin
		tok.phase      = phase_n;
		tok.failed     = failed_n;
		tok.radix_code = (phase_n == cilc_pkg::PH_ZERO) ? cilc_pkg::RC_OCT : radix_n;
		tok.minus      = minus_n;
		tok.suf_count  = cnt_n;
		tok.suf_chars  = suf_n;
		tok_span       = span_n;
	end

	// hold token state; drop it back to start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= cilc_pkg::PH_START;
			minus_q  <= 1'b0;
			radix_q  <= cilc_pkg::RC_NONE;
			failed_q <= 1'b0;
			span_q   <= '0;
			cnt_q    <= 3'd0;
		end else if (accept) begin
			if (last) begin
				phase_q  <= cilc_pkg::PH_START;
				minus_q  <= 1'b0;
				radix_q  <= cilc_pkg::RC_NONE;
				failed_q <= 1'b0;
				span_q   <= '0;
				cnt_q    <= 3'd0;
			end else begin
				phase_q  <= phase_n;
				minus_q  <= minus_n;
				radix_q  <= radix_n;
				failed_q <= failed_n;
				span_q   <= span_n;
				cnt_q    <= cnt_n;
			end
		end
	end

	// suffix characters, undefined until written
	always_ff @(posedge clk) begin
		if (accept) begin
			suf_q <= suf_n;
		end
	end

endmodule

[rtl/cilc_queue.sv]
// Short queue of token summaries between the front and back ends.
// Depends on cilc_pkg for its depth.
module cilc_queue #(
	parameter int unsigned WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             ready,
	input  logic [WIDTH-1:0] wdata,
	output logic             valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	localparam int unsigned PTR_W = (cilc_pkg::Q_DEPTH > 1) ? $clog2(cilc_pkg::Q_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(cilc_pkg::Q_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cilc_pkg::Q_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(cilc_pkg::Q_DEPTH);

	logic [WIDTH-1:0] mem_q [cilc_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign ready = cnt_q != FULL_CNT;
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && ready) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if ((push && ready) && !(pop && valid)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && ready) && (pop && valid)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push && ready) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[rtl/cilc_back.sv]
// Back end: decodes the suffix of a token summary and registers the result item.
// Depends on cilc_pkg; feeds the output channel.
module cilc_back #(
	parameter int unsigned SPAN_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        pop,
	input  cilc_pkg::cilc_tok_t         tok,
	input  logic [SPAN_BITS-1:0]        tok_span,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        valid_res,
	output logic [4:0]                  radix,
	output logic                        negative,
	output logic [15:0]                 span_len,
	output logic [2:0]                  suffix_kind
);

	localparam int unsigned OB = cilc_pkg::OUT_SPAN_BITS;

	logic        out_valid_q;
	logic        valid_c;
	logic [4:0]  rad_c;
	logic [2:0]  kind_c, sfx;
	logic [OB-1:0] span_sat, span_c;
	logic [7:0]  a, b, c;

	assign a = tok.suf_chars[0];
	assign b = tok.suf_chars[1];
	assign c = tok.suf_chars[2];

	// decode the suffix characters
	always_comb begin
		sfx = cilc_pkg::SFX_BAD;
		case (tok.suf_count)
			cilc_pkg::SUF_ONE: begin
				if (cilc_pkg::is_l(a)) sfx = cilc_pkg::SFX_L;
				else if (cilc_pkg::is_u(a)) sfx = cilc_pkg::SFX_U;
			end
			cilc_pkg::SUF_TWO: begin
				if (cilc_pkg::is_u(a)) begin
					if (cilc_pkg::is_l(b)) sfx = cilc_pkg::SFX_UL;
				end else if (cilc_pkg::is_u(b)) begin
					if (cilc_pkg::is_l(a)) sfx = cilc_pkg::SFX_UL;
				end else if (a == b && cilc_pkg::is_l(a)) begin
					sfx = cilc_pkg::SFX_LL;
				end
			end
			cilc_pkg::SUF_FULL: begin
				if (cilc_pkg::is_u(a)) begin
					if (b == c && cilc_pkg::is_l(b)) sfx = cilc_pkg::SFX_ULL;
				end else if (cilc_pkg::is_u(c)) begin
					if (a == b && cilc_pkg::is_l(a)) sfx = cilc_pkg::SFX_ULL;
				end
			end
			default: sfx = cilc_pkg::SFX_BAD;
		endcase
	end

	// saturate the span to the reported width
	generate
		if (SPAN_BITS > OB) begin : g_sat
			assign span_sat = (|tok_span[SPAN_BITS-1:OB]) ? '1 : tok_span[OB-1:0];
		end else begin : g_ext
			assign span_sat = OB'(tok_span);
		end
	endgenerate

	// form validity, radix, kind and span
	always_comb begin
		valid_c = 1'b0;
		kind_c  = cilc_pkg::SFX_NONE;
		if (!tok.failed) begin
			if (tok.phase == cilc_pkg::PH_ZERO || tok.phase == cilc_pkg::PH_DIGITS) begin
				valid_c = 1'b1;
			end else if (tok.phase == cilc_pkg::PH_SUFFIX && sfx != cilc_pkg::SFX_BAD) begin
				valid_c = 1'b1;
				kind_c  = sfx;
			end
		end
		case (tok.radix_code)
			cilc_pkg::RC_OCT: rad_c = cilc_pkg::RADIX_OCT;
			cilc_pkg::RC_DEC: rad_c = cilc_pkg::RADIX_DEC;
			cilc_pkg::RC_HEX: rad_c = cilc_pkg::RADIX_HEX;
			default:          rad_c = cilc_pkg::RADIX_NONE;
		endcase
		span_c = (tok.radix_code == cilc_pkg::RC_NONE) ? '0 : span_sat;
	end

	// take the next summary when the output register is free or being taken
	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			valid_res   <= valid_c;
			radix       <= rad_c;
			negative    <= tok.minus;
			span_len    <= span_c;
			suffix_kind <= kind_c;
		end
	end

endmodule

[rtl/c_integer_literal_classifier_core.sv]
// Top level of the C integer literal classifier: front end, summary queue, back end.
// Depends on cilc_pkg, cilc_if, cilc_front, cilc_queue and cilc_back.
//
// Feed a token one character per item on chars, with last set on its final
// character; one result item per token appears on results, and no other items.
// The block takes one character every cycle while the queue has room: the front end
// updates the token state, and on the last character pushes a token summary
// into a two-entry queue. The back end pops the summary, decodes the suffix and
// loads the output register, from which the result is offered; a summary passes
// through the queue and then the output register. A stalled result stalls the
// back end only; the front end keeps taking characters until the queue fills.
// No clearing pass after reset.
module c_integer_literal_classifier_core #(
	parameter int unsigned SPAN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cilc_char_if.sink   chars,
	cilc_res_if.source  results
);

	localparam int unsigned QW = $bits(cilc_pkg::cilc_tok_t) + SPAN_BITS;

	logic                  push, q_ready, q_valid, pop;
	cilc_pkg::cilc_tok_t   f_tok, b_tok;
	logic [SPAN_BITS-1:0]  f_span, b_span;
	logic [QW-1:0]         q_wdata, q_rdata;

	cilc_front #(.SPAN_BITS(SPAN_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.ch       (chars.ch),
		.last     (chars.last),
		.push     (push),
		.q_ready  (q_ready),
		.tok      (f_tok),
		.tok_span (f_span)
	);

	assign q_wdata = {f_tok, f_span};

	cilc_queue #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (q_ready),
		.wdata  (q_wdata),
		.valid  (q_valid),
		.pop    (pop),
		.rdata  (q_rdata)
	);

	assign b_tok  = q_rdata[QW-1:SPAN_BITS];
	assign b_span = q_rdata[SPAN_BITS-1:0];

	cilc_back #(.SPAN_BITS(SPAN_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.pop         (pop),
		.tok         (b_tok),
		.tok_span    (b_span),
		.out_valid   (results.valid),
		.out_ready   (results.ready),
		.valid_res   (results.valid_res),
		.radix       (results.radix),
		.negative    (results.negative),
		.span_len    (results.span_len),
		.suffix_kind (results.suffix_kind)
	);

	// an accepted literal always has a radix
	a_valid_radix: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.valid_res |-> results.radix != cilc_pkg::RADIX_NONE)
		else $error("valid literal without radix");

	// no radix means no digit span
	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.radix == cilc_pkg::RADIX_NONE |-> results.span_len == '0)
		else $error("digit span without radix");

	// a rejected token carries no suffix kind
	a_bad_kind: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.valid_res |-> results.suffix_kind == cilc_pkg::SFX_NONE)
		else $error("suffix kind on invalid token");

	// a summary popped from the queue shows up as a result next cycle
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> results.valid)
		else $error("popped summary lost");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the C integer literal classifier core.
// Depends on cilc_pkg, cilc_if and c_integer_literal_classifier_core; token items in,
// predicted literal classifications compared field by field with the result items.
module tb_top;

	localparam int unsigned SPAN_W = 16;

	// lexer phases of the token being predicted
	typedef enum logic [2:0] {
		LX_START, LX_FIRST, LX_ZERO, LX_HEX, LX_DIGITS, LX_SUFFIX, LX_FAIL
	} lex_phase_t;

	typedef enum logic [1:0] {BASE_NONE, BASE_OCT, BASE_DEC, BASE_HEX} base_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [4:0]  radix;
		logic        negative;
		logic [15:0] span_len;
		logic [2:0]  suffix_kind;
	} lit_class_t;

	logic clk = 1'b0;
	logic arst_n;

	cilc_char_if chars_if ();
	cilc_res_if  res_if ();

	c_integer_literal_classifier_core #(.SPAN_BITS(SPAN_W)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if)
	);

	always #1 clk = ~clk;

	// predictor state of the token in flight
	lex_phase_t       lx_phase = LX_START;
	logic             lx_minus = 1'b0;
	base_t            lx_base = BASE_NONE;
	logic [SPAN_W-1:0] lx_span = '0;
	logic [7:0]       lx_sfx [3] = '{8'h00, 8'h00, 8'h00};
	logic [2:0]       lx_sfx_n = 3'd0;
	logic             lx_failed = 1'b0;

	char_item_t char_q [$];
	lit_class_t lit_class_q [$];
	logic [7:0] tok_buf [$];
	string      hex_set = "0123456789ABCDEFabcdef";
	string      sfx_set = "uUlL";

	char_item_t next_char;
	lit_class_t want_class;
	lit_class_t got_class;
	logic       char_took = 1'b0;
	logic       hold_off = 1'b0;
	logic       calm;
	int         chars_sent = 0;
	int         results_seen = 0;
	int         fail_count = 0;
	int         total_chars;

	assign calm = chars_sent >= 500 && chars_sent < 800;

	function automatic logic dec_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic hex_char(input logic [7:0] c);
		return dec_char(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic l_char(input logic [7:0] c);
		return c == "L" || c == "l";
	endfunction

	function automatic logic u_char(input logic [7:0] c);
		return c == "U" || c == "u";
	endfunction

	function automatic void span_bump();
		if (lx_span != '1)
			lx_span++;
	endfunction

	// Advance the token state by one character; on the last one fill r and return 1.
	function automatic bit classify_char(input logic [7:0] c, input logic fin,
			output lit_class_t r);
		lex_phase_t ph;
		logic       ok;
		logic [2:0] kind;
		logic [7:0] s0, s1, s2;

		r = '0;
		ph = lx_phase;
		// optional leading minus, then the first digit
		if (ph == LX_START) begin
			if (c == cilc_pkg::CH_MINUS) begin
				lx_minus = 1'b1;
				lx_phase = LX_FIRST;
				ph = LX_FAIL;
			end else begin
				ph = LX_FIRST;
			end
		end
		if (ph == LX_FIRST) begin
			ph = LX_FAIL;
			if (!dec_char(c)) begin
				lx_failed = 1'b1;
				lx_phase = LX_FAIL;
			end else begin
				span_bump();
				if (c == "0") begin
					lx_phase = LX_ZERO;
				end else begin
					lx_base = BASE_DEC;
					lx_phase = LX_DIGITS;
				end
			end
		end
		// after a leading zero: hex prefix or octal digits
		if (ph == LX_ZERO) begin
			if (c == "x" || c == "X") begin
				span_bump();
				lx_phase = LX_HEX;
				ph = LX_FAIL;
			end else begin
				lx_base = BASE_OCT;
				lx_phase = LX_DIGITS;
				ph = LX_DIGITS;
			end
		end
		if (ph == LX_DIGITS) begin
			case (lx_base)
				BASE_OCT: ok = c >= "0" && c <= "7";
				BASE_DEC: ok = dec_char(c);
				default:  ok = hex_char(c);
			endcase
			if (ok) begin
				span_bump();
				ph = LX_FAIL;
			end else begin
				lx_phase = LX_SUFFIX;
				ph = LX_SUFFIX;
			end
		end
		// store up to three suffix characters, count up to four
		if (ph == LX_SUFFIX) begin
			if (lx_sfx_n < 3'd3)
				lx_sfx[lx_sfx_n] = c;
			if (lx_sfx_n < 3'd4)
				lx_sfx_n++;
		end
		// a hex prefix needs at least one hex digit
		if (ph == LX_HEX) begin
			if (!hex_char(c)) begin
				lx_failed = 1'b1;
				lx_phase = LX_FAIL;
			end else begin
				span_bump();
				lx_base = BASE_HEX;
				lx_phase = LX_DIGITS;
			end
		end

		if (!fin)
			return 1'b0;

		// a bare zero is octal
		if (lx_phase == LX_ZERO)
			lx_base = BASE_OCT;
		s0 = lx_sfx[0];
		s1 = lx_sfx[1];
		s2 = lx_sfx[2];
		r.valid_res = 1'b0;
		r.suffix_kind = cilc_pkg::SFX_NONE;
		if (!lx_failed) begin
			if (lx_phase == LX_ZERO || lx_phase == LX_DIGITS) begin
				r.valid_res = 1'b1;
			end else if (lx_phase == LX_SUFFIX) begin
				case (lx_sfx_n)
					3'd1: kind = l_char(s0) ? cilc_pkg::SFX_L :
						(u_char(s0) ? cilc_pkg::SFX_U : cilc_pkg::SFX_BAD);
					3'd2: begin
						if (u_char(s0))
							kind = l_char(s1) ? cilc_pkg::SFX_UL : cilc_pkg::SFX_BAD;
						else if (u_char(s1))
							kind = l_char(s0) ? cilc_pkg::SFX_UL : cilc_pkg::SFX_BAD;
						else
							kind = (s0 == s1 && l_char(s0)) ? cilc_pkg::SFX_LL :
								cilc_pkg::SFX_BAD;
					end
					3'd3: begin
						if (u_char(s0))
							kind = (s1 == s2 && l_char(s1)) ? cilc_pkg::SFX_ULL :
								cilc_pkg::SFX_BAD;
						else if (u_char(s2))
							kind = (s0 == s1 && l_char(s0)) ? cilc_pkg::SFX_ULL :
								cilc_pkg::SFX_BAD;
						else
							kind = cilc_pkg::SFX_BAD;
					end
					default: kind = cilc_pkg::SFX_BAD;
				endcase
				if (kind != cilc_pkg::SFX_BAD) begin
					r.valid_res = 1'b1;
					r.suffix_kind = kind;
				end
			end
		end
		case (lx_base)
			BASE_OCT: r.radix = cilc_pkg::RADIX_OCT;
			BASE_DEC: r.radix = cilc_pkg::RADIX_DEC;
			BASE_HEX: r.radix = cilc_pkg::RADIX_HEX;
			default:  r.radix = cilc_pkg::RADIX_NONE;
		endcase
		if (r.radix == cilc_pkg::RADIX_NONE)
			r.span_len = 16'd0;
		else if (lx_span > 'hFFFF)
			r.span_len = 16'hFFFF;
		else
			r.span_len = 16'(lx_span);
		r.negative = lx_minus;

		// ready for the next token
		lx_phase = LX_START;
		lx_minus = 1'b0;
		lx_base = BASE_NONE;
		lx_span = '0;
		lx_sfx_n = 3'd0;
		lx_failed = 1'b0;
		return 1'b1;
	endfunction

	// stimulus building: characters collect in tok_buf, end_token queues them
	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			tok_buf.push_back(s[i]);
	endtask

	task automatic end_token();
		for (int i = 0; i < tok_buf.size(); i++)
			char_q.push_back('{ch: tok_buf[i], last: (i == tok_buf.size() - 1)});
		tok_buf.delete();
	endtask

	task automatic add_suffix();
		logic [7:0] lch, uch;

		lch = $urandom_range(1) ? "L" : "l";
		uch = $urandom_range(1) ? "U" : "u";
		case ($urandom_range(7))
			1: tok_buf.push_back(lch);
			2: tok_buf.push_back(uch);
			3: begin tok_buf.push_back(uch); tok_buf.push_back(lch); end
			4: begin tok_buf.push_back(lch); tok_buf.push_back(uch); end
			5: begin tok_buf.push_back(lch); tok_buf.push_back(lch); end
			6: begin
				tok_buf.push_back(uch);
				tok_buf.push_back(lch);
				tok_buf.push_back(lch);
			end
			7: begin
				tok_buf.push_back(lch);
				tok_buf.push_back(lch);
				tok_buf.push_back(uch);
			end
			default: ;
		endcase
	endtask

	// well-formed literal with random sign, radix, digits and suffix
	task automatic add_good_token();
		if ($urandom_range(99) < 30)
			tok_buf.push_back(cilc_pkg::CH_MINUS);
		case ($urandom_range(3))
			0: begin
				tok_buf.push_back(8'("1" + $urandom_range(8)));
				repeat ($urandom_range(6))
					tok_buf.push_back(8'("0" + $urandom_range(9)));
			end
			1: begin
				tok_buf.push_back(cilc_pkg::CH_ZERO);
				repeat ($urandom_range(6))
					tok_buf.push_back(8'("0" + $urandom_range(7)));
			end
			2: begin
				tok_buf.push_back(cilc_pkg::CH_ZERO);
				tok_buf.push_back($urandom_range(1) ? cilc_pkg::CH_X_LO : cilc_pkg::CH_X_UP);
				repeat (1 + $urandom_range(5))
					tok_buf.push_back(hex_set[$urandom_range(21)]);
			end
			default: tok_buf.push_back(cilc_pkg::CH_ZERO);
		endcase
		add_suffix();
	endtask

	// random bytes, corrupted literals, overlong and misordered suffixes
	task automatic add_noise_token();
		case ($urandom_range(3))
			0: begin
				repeat (1 + $urandom_range(5))
					tok_buf.push_back(8'($urandom_range(255)));
			end
			1: begin
				add_good_token();
				tok_buf[$urandom_range(tok_buf.size() - 1)] = 8'($urandom_range(255));
			end
			2: begin
				add_good_token();
				repeat (4 + $urandom_range(2))
					tok_buf.push_back(sfx_set[$urandom_range(3)]);
			end
			default: begin
				add_good_token();
				repeat (1 + $urandom_range(1))
					tok_buf.push_back(sfx_set[$urandom_range(3)]);
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// drive character items at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!chars_if.valid || char_took)) begin
			if (char_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
				next_char = char_q.pop_front();
				chars_if.valid <= 1'b1;
				chars_if.ch <= next_char.ch;
				chars_if.last <= next_char.last;
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
	end

	// drive result ready at the falling edge, with random stalls
	always @(negedge clk) begin
		res_if.ready <= arst_n && !hold_off && (calm || $urandom_range(99) >= 12);
	end

	// hold off results long enough for the core to stall its input
	initial begin
		while (results_seen < 40)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (200)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	// sample both channels at the rising edge: check results, then predict
	always @(posedge clk) begin
		char_took = arst_n && chars_if.valid && chars_if.ready;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (lit_class_q.size() == 0) begin
				$error("result item with no token pending");
				fail_count++;
			end else begin
				want_class = lit_class_q.pop_front();
				check_field("valid_res", 16'(want_class.valid_res), 16'(res_if.valid_res));
				check_field("radix", 16'(want_class.radix), 16'(res_if.radix));
				check_field("negative", 16'(want_class.negative), 16'(res_if.negative));
				check_field("span_len", want_class.span_len, res_if.span_len);
				check_field("suffix_kind", 16'(want_class.suffix_kind),
					16'(res_if.suffix_kind));
			end
		end
		if (char_took) begin
			chars_sent++;
			if (classify_char(chars_if.ch, chars_if.last, got_class))
				lit_class_q.push_back(got_class);
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		string dir_tok [$];
		int    stop_at;

		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch = 8'h00;
		chars_if.last = 1'b0;
		res_if.ready = 1'b0;

		// directed: sign, radix edges, lone minus, bad first digit, bare zero,
		// hex without digits, every suffix form and overlong suffixes
		dir_tok = '{"-", "0", "7", "-9", "123", "0777", "089", "0x", "-0X", "0xg",
			"0XfF", "a12", "--5", "5-", "12L", "0u", "9uL", "0x1Lu", "4ll", "4lL",
			"-0LLU", "8ULL", "0x7fuLL", "12uLLx", "00Ul"};
		foreach (dir_tok[i]) begin
			add_str(dir_tok[i]);
			end_token();
		end
		tok_buf.push_back(8'h00);
		end_token();
		tok_buf.push_back(8'hFF);
		end_token();
		add_str("1");
		tok_buf.push_back(8'hFF);
		end_token();

		// random: mostly well-formed literals, the rest noise
		stop_at = 1649;
		while (char_q.size() < stop_at) begin
			if ($urandom_range(99) < 75)
				add_good_token();
			else
				add_noise_token();
			end_token();
		end

		add_str("0");
		end_token();
		total_chars = char_q.size();

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (chars_sent < total_chars)
			@(posedge clk);
		while (lit_class_q.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
